// ===== hdl/itp_pkg.sv =====
// ---------------------------------------------------------------------------
// itp_pkg
// Shared codes, channel count and channel command/response types for the
// interval timer port interface.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package itp_pkg;

    // Item operation codes
    localparam logic [1:0] OP_READ   = 2'd0;
    localparam logic [1:0] OP_WRITE  = 2'd1;
    localparam logic [1:0] OP_UPDATE = 2'd2;

    // Port select value of the control word port
    localparam logic [1:0] CTRL_PORT = 2'd3;

    // Byte access modes (zero in the access field of a control word latches)
    localparam logic [1:0] AM_LATCH = 2'd0;
    localparam logic [1:0] AM_LOW   = 2'd1;
    localparam logic [1:0] AM_HIGH  = 2'd2;

    // Counting mode that drives the output line from the bus side
    localparam logic [2:0] CM_ZERO = 3'd0;

    localparam int NUM_CH = 3;

    // Command from the decoder to one channel
    typedef struct packed {
        logic        rd_en;
        logic        wr_en;
        logic        latch_en;
        logic        mode_en;
        logic        upd_en;
        logic [7:0]  data;
        logic [15:0] count;
    } t_chan_cmd;

    // Response from one channel
    typedef struct packed {
        logic [7:0]  rd_byte;
        logic        out_line;
        logic        loaded;
        logic [15:0] load_value;
    } t_chan_rsp;

endpackage

`default_nettype wire

// ===== hdl/itp_channel.sv =====
// ---------------------------------------------------------------------------
// itp_channel
// State of one timer channel: reload word, live and latched counts, byte
// flip-flops, modes and the output line. Updates on one command per cycle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module itp_channel (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire itp_pkg::t_chan_cmd i_cmd,
    output itp_pkg::t_chan_rsp     o_rsp
);

    logic [15:0] r_reload, n_reload;
    logic [15:0] r_live, n_live;
    logic [15:0] r_latched, n_latched;
    logic        r_latch_valid, n_latch_valid;
    logic        r_read_high, n_read_high;
    logic        r_write_high, n_write_high;
    logic [1:0]  r_access, n_access;
    logic [2:0]  r_cmode, n_cmode;
    logic        r_out, n_out;

    logic        rd_high;
    logic        rd_end;
    logic        wr_high;
    logic        wr_final;
    logic [15:0] rd_src;
    logic [15:0] wr_word;
    logic        load;

    // Select the byte for a read and whether it ends a latch
    always_comb begin
        case (r_access)
            itp_pkg::AM_LOW: begin
                rd_high = 1'b0;
                rd_end  = 1'b1;
            end
            itp_pkg::AM_HIGH: begin
                rd_high = 1'b1;
                rd_end  = 1'b1;
            end
            default: begin
                rd_high = r_read_high;
                rd_end  = r_read_high;
            end
        endcase
    end

    // Select the byte for a write and whether it completes the count
    always_comb begin
        case (r_access)
            itp_pkg::AM_LOW: begin
                wr_high  = 1'b0;
                wr_final = 1'b1;
            end
            itp_pkg::AM_HIGH: begin
                wr_high  = 1'b1;
                wr_final = 1'b1;
            end
            default: begin
                wr_high  = r_write_high;
                wr_final = r_write_high;
            end
        endcase
    end

    assign rd_src  = r_latch_valid ? r_latched : r_live;
    assign wr_word = wr_high ? {i_cmd.data, r_reload[7:0]} : {r_reload[15:8], i_cmd.data};
    assign load    = i_cmd.wr_en && wr_final && (r_cmode == itp_pkg::CM_ZERO);

    // Next state for the channel
    always_comb begin
        n_reload      = r_reload;
        n_live        = r_live;
        n_latched     = r_latched;
        n_latch_valid = r_latch_valid;
        n_read_high   = r_read_high;
        n_write_high  = r_write_high;
        n_access      = r_access;
        n_cmode       = r_cmode;
        n_out         = r_out;

        if (i_cmd.rd_en) begin
            if (rd_end) begin
                n_latch_valid = 1'b0;
            end
            if (r_access != itp_pkg::AM_LOW && r_access != itp_pkg::AM_HIGH) begin
                n_read_high = ~r_read_high;
            end
        end

        if (i_cmd.wr_en) begin
            n_reload = wr_word;
            if (r_access != itp_pkg::AM_LOW && r_access != itp_pkg::AM_HIGH) begin
                n_write_high = ~r_write_high;
            end
            if (load) begin
                n_out  = 1'b1;
                n_live = wr_word;
            end
        end

        if (i_cmd.latch_en) begin
            n_latched     = r_live;
            n_latch_valid = 1'b1;
            n_read_high   = 1'b0;
        end

        if (i_cmd.mode_en) begin
            n_access = i_cmd.data[5:4];
            n_cmode  = i_cmd.data[3:1];
            if (i_cmd.data[3:1] == itp_pkg::CM_ZERO) begin
                n_out = 1'b0;
            end
        end

        if (i_cmd.upd_en) begin
            n_live = i_cmd.count;
        end
    end

    // Hold channel state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reload      <= '0;
            r_live        <= '0;
            r_latched     <= '0;
            r_latch_valid <= 1'b0;
            r_read_high   <= 1'b0;
            r_write_high  <= 1'b0;
            r_access      <= '0;
            r_cmode       <= '0;
            r_out         <= 1'b0;
        end else begin
            r_reload      <= n_reload;
            r_live        <= n_live;
            r_latched     <= n_latched;
            r_latch_valid <= n_latch_valid;
            r_read_high   <= n_read_high;
            r_write_high  <= n_write_high;
            r_access      <= n_access;
            r_cmode       <= n_cmode;
            r_out         <= n_out;
        end
    end

    // Drive the response for this cycle's command
    always_comb begin
        o_rsp.rd_byte    = '0;
        if (i_cmd.rd_en) begin
            o_rsp.rd_byte = rd_high ? rd_src[15:8] : rd_src[7:0];
        end
        o_rsp.out_line   = n_out;
        o_rsp.loaded     = load;
        o_rsp.load_value = load ? wr_word : 16'd0;
    end

endmodule

`default_nettype wire

// ===== hdl/interval_timer_port_interface.sv =====
// ---------------------------------------------------------------------------
// interval_timer_port_interface
// Bus side of a three-channel interval timer: port reads, port writes,
// control words and count updates from the counting engine.
// ---------------------------------------------------------------------------
// Path: input register, then result register; channel state is updated as
// the item moves between them.
// Throughput: one item per cycle; the result register stalls the input side
// only while a result waits and the next item is ready to move.
// Reset: synchronous, active low; clears all channel state and both valids.
`timescale 1ns / 1ps
`default_nettype none

module interval_timer_port_interface (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Input channel
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [1:0]  i_op,
    input  wire logic [1:0]  i_port_select,
    input  wire logic [7:0]  i_write_data,
    input  wire logic [15:0] i_count_value,
    // Output channel
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [7:0]       o_read_data,
    output logic [2:0]       o_out_pins,
    output logic             o_count_loaded,
    output logic [1:0]       o_loaded_channel,
    output logic [15:0]      o_loaded_value
);

    logic        r_in_valid;
    logic [1:0]  r_op;
    logic [1:0]  r_sel;
    logic [7:0]  r_data;
    logic [15:0] r_count;

    logic        r_out_valid;
    logic [7:0]  r_read_data;
    logic [2:0]  r_out_pins;
    logic        r_loaded;
    logic [1:0]  r_loaded_ch;
    logic [15:0] r_loaded_val;

    logic        out_blocked;
    logic        proc;
    logic        is_ctrl;
    logic [1:0]  ctrl_ch;

    itp_pkg::t_chan_cmd chan_cmd [itp_pkg::NUM_CH];
    itp_pkg::t_chan_rsp chan_rsp [itp_pkg::NUM_CH];

    logic [7:0]  n_read_data;
    logic [2:0]  n_out_pins;
    logic        n_loaded;
    logic [1:0]  n_loaded_ch;
    logic [15:0] n_loaded_val;

    // Handshake: move the held item when the result register can take it
    assign out_blocked = r_out_valid && i_out_stall;
    assign o_in_stall  = r_in_valid && out_blocked;
    assign proc        = r_in_valid && !out_blocked;

    // Capture an item into the input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_op    <= i_op;
            r_sel   <= i_port_select;
            r_data  <= i_write_data;
            r_count <= i_count_value;
        end
    end

    // Decode the item into per-channel commands
    assign is_ctrl = proc && (r_op == itp_pkg::OP_WRITE) && (r_sel == itp_pkg::CTRL_PORT);
    assign ctrl_ch = r_data[7:6];

    for (genvar g = 0; g < itp_pkg::NUM_CH; g++) begin : g_ch
        logic hit;
        logic ctl_hit;

        assign hit     = proc && (r_sel == 2'(g));
        assign ctl_hit = is_ctrl && (ctrl_ch == 2'(g));

        always_comb begin
            chan_cmd[g].rd_en    = hit && (r_op == itp_pkg::OP_READ);
            chan_cmd[g].wr_en    = hit && (r_op == itp_pkg::OP_WRITE);
            chan_cmd[g].upd_en   = hit && (r_op == itp_pkg::OP_UPDATE);
            chan_cmd[g].latch_en = ctl_hit && (r_data[5:4] == itp_pkg::AM_LATCH);
            chan_cmd[g].mode_en  = ctl_hit && (r_data[5:4] != itp_pkg::AM_LATCH);
            chan_cmd[g].data     = r_data;
            chan_cmd[g].count    = r_count;
        end

        itp_channel u_channel (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cmd   (chan_cmd[g]),
            .o_rsp   (chan_rsp[g])
        );
    end

    // Merge channel responses into one result
    always_comb begin
        n_read_data  = '0;
        n_loaded     = 1'b0;
        n_loaded_ch  = '0;
        n_loaded_val = '0;
        for (int k = 0; k < itp_pkg::NUM_CH; k++) begin
            n_read_data   = n_read_data | chan_rsp[k].rd_byte;
            n_out_pins[k] = chan_rsp[k].out_line;
            if (chan_rsp[k].loaded) begin
                n_loaded     = 1'b1;
                n_loaded_ch  = 2'(k);
                n_loaded_val = chan_rsp[k].load_value;
            end
        end
    end

    // Hold the result until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!out_blocked) begin
            r_out_valid <= proc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc) begin
            r_read_data  <= n_read_data;
            r_out_pins   <= n_out_pins;
            r_loaded     <= n_loaded;
            r_loaded_ch  <= n_loaded_ch;
            r_loaded_val <= n_loaded_val;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_read_data      = r_read_data;
    assign o_out_pins       = r_out_pins;
    assign o_count_loaded   = r_loaded;
    assign o_loaded_channel = r_loaded_ch;
    assign o_loaded_value   = r_loaded_val;

endmodule

`default_nettype wire
